// ----- sv/isp_pkg.sv -----
// shared constants, types and state codes for the inductive steering pd controller
`timescale 1ns / 1ps

package isp_pkg;

  // sample and fixed point format
  localparam int ADC_BITS   = 12;
  localparam int FRAC_BITS  = 8;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int POS_SCALE  = 100 * ONE;
  localparam int SUM_OFFSET = 10;
  localparam int K_DIV      = 100;

  // divide by 100 as a reciprocal product, exact for numerators below 43690
  localparam int K_RECIP = 20972;
  localparam int K_SHIFT = 21;

  // field widths
  localparam int SUB_W    = ADC_BITS + 2;
  localparam int SUM_W    = ADC_BITS + 3;
  localparam int POS_W    = 16;
  localparam int ERR_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int ACC_W    = 32;
  localparam int GAIN_W   = 12;
  localparam int STEER_W  = 16;
  localparam int LIM_W    = 15;
  localparam int RATIO_W  = 9;
  localparam int BASE_W   = 8;
  localparam int SPEED_W  = 17;
  localparam int SPEED_MAX = (1 << SPEED_W) - 1;

  // shared multiplier
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // iterative divider
  localparam int DIV_N_W   = 28;
  localparam int DIV_D_W   = 15;
  localparam int DIV_Q_W   = 15;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_TARGET_POS  = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_STEER_LIMIT = 3'd4,
    REG_DIFF_LIMIT  = 3'd5,
    REG_OUTER_GAIN  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MPOS,
    ST_DPOS,
    ST_PWAIT,
    ST_ERR,
    ST_MKP,
    ST_MKD,
    ST_ACC,
    ST_RND,
    ST_DK,
    ST_KWAIT,
    ST_MOG,
    ST_MOUT,
    ST_MIN,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ----- sv/isp_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module isp_mul (
  input  logic                                clk,
  input  isp_pkg::mul_req_t                   req,
  output logic signed [isp_pkg::PROD_W-1:0]  prod
);
  import isp_pkg::*;

  logic signed [MUL_A_W-1:0] a;
  logic signed [MUL_B_W-1:0] b;

  assign a = req.a;
  assign b = req.b;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- sv/isp_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module isp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  isp_pkg::div_req_t            req,
  output logic                         done,
  output logic [isp_pkg::DIV_Q_W-1:0]  quot
);
  import isp_pkg::*;

  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   den;
  logic [DIV_Q_W-1:0]   shreg;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  // quotient is known to fit DIV_Q_W bits, so the upper dividend bits start as remainder
  assign trial = {rem, shreg[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        count <= DIV_CNT_W'(DIV_Q_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= DIV_D_W'(req.num >> DIV_Q_W);
      shreg <= req.num[DIV_Q_W-1:0];
      den   <= req.den;
    end else if (count != '0) begin
      rem   <= fits ? DIV_D_W'(trial - {1'b0, den}) : DIV_D_W'(trial);
      shreg <= {shreg[DIV_Q_W-2:0], fits};
    end
  end

endmodule

// ----- sv/inductive_steering_pd_controller.sv -----
// top level: register port, sequencer and datapath of the steering controller
`timescale 1ns / 1ps

// Each transaction on the slave stream carries five 12 bit inductor samples; the block
// returns one transaction on the master stream with the line position (signed Q8.8
// percent), the clamped PD steering output (signed Q8.8) and the left and right wheel
// targets (unsigned Q.8). The next item is taken only once the sequencer has returned
// to idle after the last one: the 15-step restoring divider computes the position
// quotient while the sequencer waits for it, and seven products go one at a time
// through the single shared multiplier, the ratio divide by 100 among them as a
// reciprocal product. s_tready is high only while the sequencer is idle; a finished
// result waits in the output register so the next item can be taken before it is
// collected, but while an earlier result is still held the sequencer waits in its last
// step until the output register is free.
// Registers are written through the APB port at byte address 4*index and should only be
// changed while no item is in flight.
module inductive_steering_pd_controller (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] left_horiz, [23:12] left_vert, [35:24] middle, [47:36] right_vert,
  // [59:48] right_horiz, [63:60] zero
  input  logic [63:0] s_tdata,
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] position, [31:16] steer_out, [48:32] left_speed, [65:49] right_speed,
  // [71:66] zero
  output logic [71:0] m_tdata,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import isp_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        deriv_gain;
  logic signed [POS_W-1:0]  target_position;
  logic [BASE_W-1:0]        base_speed;
  logic [LIM_W-1:0]         steer_limit;
  logic [RATIO_W-1:0]       diff_limit;
  logic [RATIO_W-1:0]       outer_gain;

  logic     cfg_write;
  reg_idx_t cfg_idx;

  // sequencer and shared units
  state_t   state;
  state_t   state_next;
  mul_req_t mul_req;
  div_req_t div_req;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_u;
  logic                     div_done;
  logic [DIV_Q_W-1:0]       quot;

  // datapath registers
  logic signed [SUB_W-1:0]   sub;
  logic [SUM_W-1:0]          sum;
  logic signed [POS_W-1:0]   pos;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [STEER_W-1:0] steer;
  logic [RATIO_W-1:0]        kmag;
  logic                      kneg;
  logic [SPEED_W-1:0]        outer_spd;
  logic [SPEED_W-1:0]        inner_spd;

  // output register
  logic signed [POS_W-1:0]   out_pos;
  logic signed [STEER_W-1:0] out_steer;
  logic [SPEED_W-1:0]        out_left;
  logic [SPEED_W-1:0]        out_right;

  // combinational datapath terms
  logic [ADC_BITS-1:0]       lh, lv, md, rv, rh;
  logic signed [SUB_W-1:0]   sub_calc;
  logic [SUM_W-1:0]          sum_calc;
  logic [SUB_W-2:0]          sub_mag;
  logic [DIV_Q_W-1:0]        pos_mag;
  logic signed [POS_W-1:0]   pos_calc;
  logic signed [ERR_W-1:0]   err_calc;
  logic signed [DIFF_W-1:0]  diff_calc;
  logic [ACC_W-1:0]          acc_mag;
  logic [ACC_W-FRAC_BITS-1:0] rnd;
  logic [LIM_W-1:0]          steer_mag;
  logic signed [STEER_W-1:0] steer_calc;
  logic [LIM_W-1:0]          steer_abs;
  logic [DIV_Q_W-1:0]        k_quot;
  logic [RATIO_W-1:0]        kmag_calc;
  logic [PROD_W-1:0]         outer_rnd;
  logic [SPEED_W-1:0]        outer_calc;
  logic [SPEED_W-1:0]        inner_calc;
  logic                      out_free;

  // ---------------------------------------------------------------- register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= GAIN_W'(166);
      deriv_gain      <= GAIN_W'(481);
      target_position <= '0;
      base_speed      <= BASE_W'(30);
      steer_limit     <= LIM_W'(21760);
      diff_limit      <= RATIO_W'(166);
      outer_gain      <= RATIO_W'(51);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_PROP_GAIN:   prop_gain       <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain      <= pwdata[GAIN_W-1:0];
        REG_TARGET_POS:  target_position <= pwdata[POS_W-1:0];
        REG_BASE_SPEED:  base_speed      <= pwdata[BASE_W-1:0];
        REG_STEER_LIMIT: steer_limit     <= pwdata[LIM_W-1:0];
        REG_DIFF_LIMIT:  diff_limit      <= pwdata[RATIO_W-1:0];
        REG_OUTER_GAIN:  outer_gain      <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:   prdata = 32'(prop_gain);
      REG_DERIV_GAIN:  prdata = 32'(deriv_gain);
      REG_TARGET_POS:  prdata = 32'(unsigned'(target_position));
      REG_BASE_SPEED:  prdata = 32'(base_speed);
      REG_STEER_LIMIT: prdata = 32'(steer_limit);
      REG_DIFF_LIMIT:  prdata = 32'(diff_limit);
      REG_OUTER_GAIN:  prdata = 32'(outer_gain);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- shared units
  isp_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  isp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  assign prod_u = prod;

  // ---------------------------------------------------------------- datapath terms
  assign lh = s_tdata[ADC_BITS-1:0];
  assign lv = s_tdata[2*ADC_BITS-1:ADC_BITS];
  assign md = s_tdata[3*ADC_BITS-1:2*ADC_BITS];
  assign rv = s_tdata[4*ADC_BITS-1:3*ADC_BITS];
  assign rh = s_tdata[5*ADC_BITS-1:4*ADC_BITS];

  // difference of the four side coils and sum of all five coils, offset keeps the divisor non-zero
  assign sub_calc = SUB_W'(lh) + SUB_W'(lv) - SUB_W'(rh) - SUB_W'(rv);
  assign sum_calc = SUM_W'(lh) + SUM_W'(lv) + SUM_W'(md) + SUM_W'(rv) + SUM_W'(rh)
                  + SUM_W'(SUM_OFFSET);

  assign sub_mag = sub[SUB_W-1] ? (SUB_W-1)'(-sub) : (SUB_W-1)'(sub);

  // position: quotient magnitude clamped to 100 percent, sign from the difference
  assign pos_mag  = (quot > DIV_Q_W'(POS_SCALE)) ? DIV_Q_W'(POS_SCALE) : quot;
  assign pos_calc = sub[SUB_W-1] ? -POS_W'(pos_mag) : POS_W'(pos_mag);

  assign err_calc  = ERR_W'(target_position) - ERR_W'(pos);
  assign diff_calc = DIFF_W'(err_calc) - DIFF_W'(prev_error);

  // round half away from zero on the magnitude, then clamp to the steering limit
  assign acc_mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign rnd        = (ACC_W-FRAC_BITS)'((acc_mag + ACC_W'(ONE / 2)) >> FRAC_BITS);
  assign steer_mag  = (rnd > (ACC_W-FRAC_BITS)'(steer_limit)) ? steer_limit
                                                              : rnd[LIM_W-1:0];
  assign steer_calc = acc[ACC_W-1] ? -STEER_W'(steer_mag) : STEER_W'(steer_mag);
  assign steer_abs  = steer[STEER_W-1] ? LIM_W'(-steer) : LIM_W'(steer);

  // ratio: rounded divide by 100 from the reciprocal product, clamped to the limit
  assign k_quot    = DIV_Q_W'(prod_u >> K_SHIFT);
  assign kmag_calc = (k_quot > DIV_Q_W'(diff_limit)) ? diff_limit : k_quot[RATIO_W-1:0];

  // outer wheel: rounded product, saturated to the speed field
  assign outer_rnd  = (prod_u + PROD_W'(ONE / 2)) >> FRAC_BITS;
  assign outer_calc = (outer_rnd > PROD_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                       : outer_rnd[SPEED_W-1:0];
  // inner wheel: factor may go below zero, floor at zero
  assign inner_calc = prod[PROD_W-1]                 ? '0 :
                      (prod_u > PROD_W'(SPEED_MAX))  ? SPEED_W'(SPEED_MAX) :
                                                       prod_u[SPEED_W-1:0];

  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MPOS;
      ST_MPOS:  state_next = ST_DPOS;
      ST_DPOS:  state_next = ST_PWAIT;
      ST_PWAIT: if (div_done) state_next = ST_ERR;
      ST_ERR:   state_next = ST_MKP;
      ST_MKP:   state_next = ST_MKD;
      ST_MKD:   state_next = ST_ACC;
      ST_ACC:   state_next = ST_RND;
      ST_RND:   state_next = ST_DK;
      ST_DK:    state_next = ST_KWAIT;
      ST_KWAIT: state_next = ST_MOG;
      ST_MOG:   state_next = ST_MOUT;
      ST_MOUT:  state_next = ST_MIN;
      ST_MIN:   state_next = ST_FIN;
      ST_FIN:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // operands for the shared multiplier, requests to the divider and the input ready
  always_comb begin
    mul_req  = '0;
    div_req  = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_MPOS: begin
        mul_req.a = MUL_A_W'(sub_mag);
        mul_req.b = MUL_B_W'(POS_SCALE);
      end
      ST_DPOS: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_N_W'(prod_u) + DIV_N_W'(sum >> 1);
        div_req.den   = DIV_D_W'(sum);
      end
      ST_MKP: begin
        mul_req.a = MUL_A_W'(err);
        mul_req.b = MUL_B_W'(prop_gain);
      end
      ST_MKD: begin
        mul_req.a = MUL_A_W'(diff);
        mul_req.b = MUL_B_W'(deriv_gain);
      end
      ST_DK: begin
        // half of 100 added first so the truncating product rounds to nearest
        mul_req.a = MUL_A_W'(steer_abs) + MUL_A_W'(K_DIV / 2);
        mul_req.b = MUL_B_W'(K_RECIP);
      end
      ST_MOG: begin
        mul_req.a = MUL_A_W'(kmag);
        mul_req.b = MUL_B_W'(outer_gain);
      end
      ST_MOUT: begin
        // one squared plus ratio times outer fraction, all Q4.16
        mul_req.a = MUL_A_W'(ONE * ONE) + prod_u[MUL_A_W-1:0];
        mul_req.b = MUL_B_W'(base_speed);
      end
      ST_MIN: begin
        mul_req.a = MUL_A_W'(ONE) - MUL_A_W'(kmag);
        mul_req.b = MUL_B_W'(base_speed);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (state == ST_ERR) begin
      prev_error <= err_calc;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sub <= sub_calc;
          sum <= sum_calc;
        end
      end
      ST_PWAIT: if (div_done) pos <= pos_calc;
      ST_ERR: begin
        err  <= err_calc;
        diff <= diff_calc;
      end
      ST_MKD:   acc <= ACC_W'(prod);
      ST_ACC:   acc <= acc + ACC_W'(prod);
      ST_RND:   steer <= steer_calc;
      ST_KWAIT: begin
        kmag <= kmag_calc;
        kneg <= steer[STEER_W-1] && (kmag_calc != '0);
      end
      ST_MIN:   outer_spd <= outer_calc;
      ST_FIN:   inner_spd <= inner_calc;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // left turn puts the inner wheel on the left
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_pos   <= pos;
      out_steer <= steer;
      out_left  <= kneg ? inner_spd : outer_spd;
      out_right <= kneg ? outer_spd : inner_spd;
    end
  end

  assign m_tdata = {6'b0, out_right, out_left, out_steer, out_pos};

  // ---------------------------------------------------------------- assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_PWAIT))
    else $error("divider finished outside its wait state");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_pos <= POS_W'(POS_SCALE) && out_pos >= -POS_W'(POS_SCALE)))
    else $error("position beyond 100 percent");

endmodule
